// File: rtl/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants for the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // Request codes on the cmd field
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_INIT   = 2'd3;

  localparam logic [6:0] LINE_TWO_RESET = 7'd64;
  localparam logic [1:0] LINE_ONE       = 2'd1;
  localparam logic [7:0] SET_DDRAM      = 8'h80;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_BYTE,
    OP_INIT
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        rs;
  } op_entry_t;

  // Command bytes sent after the nibble wake-up sequence
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h01;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/char_lcd_4bit_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_core
// Drives an HD44780-style character LCD over a 4-bit bus from a stream of
// tick and request transactions, one result transaction per input.
// ----------------------------------------------------------------------------
// Path: the input transaction is written to the queue at its accepting
//   edge, and the sequencer step later pops it from the queue head and loads
//   the result register; a held result delays the pop.
// Throughput: one transaction per cycle while the result is taken, set by
//   the sequencer step in the back end; a held result fills the two-entry queue.
// Reset (rst, synchronous): empties the queue, returns the sequencer to idle
//   with all pins low, and loads line_two_address with 64.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write: line_two_address
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  // request transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  value,
  input  logic        reg_select,
  input  logic [5:0]  column,
  input  logic [1:0]  line,
  // result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic        pin_rs,
  output logic        pin_enable,
  output logic [3:0]  pin_data,
  output logic        busy_res,
  output logic        rejected
);

  lcdws_pkg::op_entry_t front_entry;
  lcdws_pkg::op_entry_t head_entry;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;

  // Front: classify each request; cursor moves become set-address bytes
  lcdws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .value      (value),
    .reg_select (reg_select),
    .column     (column),
    .line       (line),
    .entry      (front_entry)
  );

  // Accept whenever the queue has room, independent of the back end
  assign in_ready = !q_full;

  lcdws_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && in_ready),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head_entry)
  );

  // Back: advance the bus sequence and hold each result until taken
  lcdws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pin_rs     (pin_rs),
    .pin_enable (pin_enable),
    .pin_data   (pin_data),
    .busy_res   (busy_res),
    .rejected   (rejected)
  );

endmodule

// File: rtl/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front
// Holds the line-two base register and classifies each request into an
// operation: tick, byte to send (with RS), or start of initialization.
// ----------------------------------------------------------------------------
module lcdws_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_data,
  input  logic [1:0]            cmd,
  input  logic [7:0]            value,
  input  logic                  reg_select,
  input  logic [5:0]            column,
  input  logic [1:0]            line,
  output lcdws_pkg::op_entry_t  entry
);

  logic [6:0] line_two_address;
  logic [6:0] base;
  logic [6:0] addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_two_address <= lcdws_pkg::LINE_TWO_RESET;
    end else if (cfg_valid) begin
      line_two_address <= cfg_data;
    end
  end

  // Column counts from one; wrap modulo 128
  assign base = (line != lcdws_pkg::LINE_ONE) ? line_two_address : 7'd0;
  assign addr = base + {1'b0, column} - 7'd1;

  always_comb begin
    entry.kind = lcdws_pkg::OP_TICK;
    entry.data = value;
    entry.rs   = reg_select;
    case (cmd)
      lcdws_pkg::CMD_TICK: begin
        entry.kind = lcdws_pkg::OP_TICK;
      end
      lcdws_pkg::CMD_WRITE: begin
        entry.kind = lcdws_pkg::OP_BYTE;
      end
      lcdws_pkg::CMD_CURSOR: begin
        entry.kind = lcdws_pkg::OP_BYTE;
        entry.data = lcdws_pkg::SET_DDRAM | {1'b0, addr};
        entry.rs   = 1'b0;
      end
      default: begin
        entry.kind = lcdws_pkg::OP_INIT;
      end
    endcase
  end

endmodule

// File: rtl/lcdws_queue.sv
// ----------------------------------------------------------------------------
// lcdws_queue
// Small FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module lcdws_queue #(
  parameter int Depth = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lcdws_pkg::op_entry_t  push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output lcdws_pkg::op_entry_t  head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  lcdws_pkg::op_entry_t slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back
// Carries out queued operations (nibble strobing, init sequence and waits),
// one per cycle unless a held result stalls, into a registered result stage.
// ----------------------------------------------------------------------------
module lcdws_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  lcdws_pkg::op_entry_t  q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  pin_rs,
  output logic                  pin_enable,
  output logic [3:0]            pin_data,
  output logic                  busy_res,
  output logic                  rejected
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_BYTE,
    MODE_INIT
  } mode_t;

  mode_t       mode, mode_next;
  logic [4:0]  wait_count, wait_count_next;
  logic [3:0]  init_step, init_step_next;
  logic [1:0]  nibble_phase, nibble_phase_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic        rs_level, rs_level_next;
  logic        enable_level, enable_level_next;
  logic [3:0]  data_level, data_level_next;
  logic        rej_next;
  logic        busy;
  logic        do_step;
  logic        do_start;
  logic [4:0]  wait_dec;
  logic [7:0]  step_byte;

  assign busy  = (mode == MODE_BYTE) || (mode == MODE_INIT);
  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    mode_next         = mode;
    wait_count_next   = wait_count;
    init_step_next    = init_step;
    nibble_phase_next = nibble_phase;
    pending_byte_next = pending_byte;
    rs_level_next     = rs_level;
    enable_level_next = enable_level;
    data_level_next   = data_level;
    rej_next          = 1'b0;
    do_step           = 1'b0;
    do_start          = 1'b0;
    wait_dec          = (wait_count != '0) ? wait_count - 5'd1 : 5'd0;
    step_byte         = lcdws_pkg::init_byte(2'(init_step + 4'd1 - 4'd6));

    case (q_entry.kind)
      lcdws_pkg::OP_TICK: begin
        if (busy) begin
          if (nibble_phase == 2'd1) begin
            enable_level_next = 1'b1;
            nibble_phase_next = 2'd2;
          end else if (nibble_phase == 2'd2) begin
            enable_level_next = 1'b0;
            nibble_phase_next = 2'd0;
            if (wait_count == 5'd1) begin
              // high nibble done: low nibble follows
              wait_count_next   = 5'd0;
              data_level_next   = pending_byte[3:0];
              nibble_phase_next = 2'd1;
            end else if (mode == MODE_BYTE) begin
              mode_next = MODE_IDLE;
            end else if (init_step == 4'd5) begin
              do_step = 1'b1;
            end else begin
              wait_count_next = 5'd5;
            end
          end else begin
            wait_count_next = wait_dec;
            if (wait_dec == '0) begin
              if (mode == MODE_INIT) begin
                do_step = 1'b1;
              end else begin
                mode_next = MODE_IDLE;
              end
            end
          end
        end
      end
      lcdws_pkg::OP_BYTE: begin
        if (busy) begin
          rej_next = 1'b1;
        end else begin
          mode_next         = MODE_BYTE;
          rs_level_next     = q_entry.rs;
          pending_byte_next = q_entry.data;
          wait_count_next   = 5'd1;
          data_level_next   = q_entry.data[7:4];
          enable_level_next = 1'b0;
          nibble_phase_next = 2'd1;
        end
      end
      default: begin
        if (busy) begin
          rej_next = 1'b1;
        end else begin
          mode_next      = MODE_INIT;
          init_step_next = 4'd0;
          do_start       = 1'b1;
        end
      end
    endcase

    if (do_step) begin
      init_step_next = init_step + 4'd1;
      do_start       = 1'b1;
    end

    if (do_start) begin
      nibble_phase_next = 2'd0;
      case (init_step_next)
        4'd0: begin
          wait_count_next = 5'd30;
        end
        4'd1: begin
          rs_level_next     = 1'b0;
          enable_level_next = 1'b0;
          wait_count_next   = 5'd15;
        end
        4'd2, 4'd3, 4'd4, 4'd5: begin
          wait_count_next   = 5'd0;
          data_level_next   = (init_step_next == 4'd5) ? 4'h2 : 4'h3;
          enable_level_next = 1'b0;
          nibble_phase_next = 2'd1;
        end
        4'd6, 4'd7, 4'd8, 4'd9: begin
          rs_level_next     = 1'b0;
          pending_byte_next = step_byte;
          wait_count_next   = 5'd1;
          data_level_next   = step_byte[7:4];
          enable_level_next = 1'b0;
          nibble_phase_next = 2'd1;
        end
        4'd10: begin
          wait_count_next = 5'd5;
        end
        default: begin
          // sequence complete: raise RS for data writes
          rs_level_next   = 1'b1;
          mode_next       = MODE_IDLE;
          init_step_next  = 4'd0;
          wait_count_next = 5'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      wait_count   <= '0;
      init_step    <= '0;
      nibble_phase <= '0;
      pending_byte <= '0;
      rs_level     <= 1'b0;
      enable_level <= 1'b0;
      data_level   <= '0;
      out_valid    <= 1'b0;
      pin_rs       <= 1'b0;
      pin_enable   <= 1'b0;
      pin_data     <= '0;
      busy_res     <= 1'b0;
      rejected     <= 1'b0;
    end else begin
      if (q_pop) begin
        mode         <= mode_next;
        wait_count   <= wait_count_next;
        init_step    <= init_step_next;
        nibble_phase <= nibble_phase_next;
        pending_byte <= pending_byte_next;
        rs_level     <= rs_level_next;
        enable_level <= enable_level_next;
        data_level   <= data_level_next;
        out_valid    <= 1'b1;
        pin_rs       <= rs_level_next;
        pin_enable   <= enable_level_next;
        pin_data     <= data_level_next;
        busy_res     <= (mode_next == MODE_BYTE) || (mode_next == MODE_INIT);
        rejected     <= rej_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_enable_in_strobe: assert property (@(posedge clk) disable iff (rst)
    enable_level == (nibble_phase == 2'd2))
    else $error("enable level out of step with nibble phase");

  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= 5'd30)
    else $error("wait count beyond longest delay");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("request rejected while idle");

  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && pin_enable |-> busy_res)
    else $error("enable high with no sequence running");

endmodule
